### hw/rtl/sjsd_pkg.sv
package sjsd_pkg;

    localparam int MAX_BEAMS_DEF = 2048;

    localparam int RANGE_W = 16;
    localparam int INDEX_W = 11;
    localparam int LEN_W   = 5;

    localparam logic [LEN_W-1:0] SEG_LEN_MAX = 5'd31;

    // configuration register indexes
    localparam logic [1:0] CFG_JUMP_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH      = 2'd1;
    localparam logic [1:0] CFG_MAX_START_RANGE = 2'd2;

    localparam logic [RANGE_W-1:0] JUMP_THRESHOLD_RST  = 16'd200;
    localparam logic [LEN_W-1:0]   MAX_LENGTH_RST      = 5'd15;
    localparam logic [RANGE_W-1:0] MAX_START_RANGE_RST = 16'd2500;

    typedef struct packed {
        logic [INDEX_W-1:0] start_index;
        logic [RANGE_W-1:0] start_range;
        logic [LEN_W-1:0]   run_length;
        logic               final_of_item;
    } t_result;

    // up to two results handed from the tracker to the output queue together
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

### hw/rtl/sjsd_outq.sv
module sjsd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sjsd_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_valid,
    output sjsd_pkg::t_result o_head,
    output logic [1:0]       o_count
);

    sjsd_pkg::t_result r_q [2];
    sjsd_pkg::t_result n_q [2];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic [1:0]        base;

    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        base   = r_cnt - {1'b0, i_pop};
        if (i_pop) begin
            n_q[0] = r_q[1];
        end
        case (base)
            2'd0: begin
                if (i_push.count != 2'd0) begin
                    n_q[0] = i_push.first;
                end
                if (i_push.count == 2'd2) begin
                    n_q[1] = i_push.second;
                end
            end
            2'd1: begin
                if (i_push.count != 2'd0) begin
                    n_q[1] = i_push.first;
                end
            end
            default: ;
        endcase
        n_cnt = base + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];
    assign o_count = r_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue over capacity");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, i_push.count} + {1'b0, r_cnt}) <= (3'd2 + {2'b0, i_pop}))
        else $error("push into full output queue");

    // a non-final head always has its partner from the same item queued behind it
    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0 && !r_q[0].final_of_item) |-> r_cnt == 2'd2)
        else $error("second result of an item lost");

endmodule

### hw/rtl/scan_jump_segment_detector_core.sv
// Jump-distance segment detector for a laser range scan. Feed one range sample (mm) per item,
// with i_scan_end on the last sample of a scan; the first sample of each scan counts as zero.
// A step of at least jump_threshold opens a segment, which grows while neighbouring samples
// differ by less than the threshold; a closed segment no longer than max_length (runs saturate
// at 31) and starting no farther than max_start_range comes out as start index, start range and
// length. An item yields zero, one or two results; o_final_of_item marks the last of them.
// Each item passes through the input register and its results land in a two-entry output
// queue, so an item is accepted every cycle as long as items give at most one result each and
// i_stall stays low; an item giving two results can stall the input while the output channel
// drains, which it does at one result a cycle while i_stall is low. Configuration (index 0
// jump_threshold, 1 max_length, 2 max_start_range, others ignored) is always ready and must be
// written only while the block is idle.
module scan_jump_segment_detector_core #(
    parameter int MAX_BEAMS = sjsd_pkg::MAX_BEAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_range_mm,
    input  logic        i_scan_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_start_index,
    output logic [15:0] o_start_range,
    output logic [4:0]  o_run_length,
    output logic        o_final_of_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int BW = $clog2(MAX_BEAMS);
    localparam logic [BW-1:0] BEAM_LAST = BW'(MAX_BEAMS - 1);

    // configuration
    logic [15:0] r_jump_threshold;
    logic [4:0]  r_max_length;
    logic [15:0] r_max_start_range;

    // input register
    logic        r_in_valid;
    logic [15:0] r_in_range;
    logic        r_in_last;

    // tracking state
    logic          r_in_seg,  n_in_seg;
    logic [15:0]   r_prev,    n_prev;
    logic [BW-1:0] r_beam,    n_beam;
    logic [BW-1:0] r_sidx,    n_sidx;
    logic [15:0]   r_srange,  n_srange;
    logic [4:0]    r_slen,    n_slen;

    logic [15:0]   diff;
    logic [15:0]   cmp;
    logic          taken;
    logic          rep_break;
    logic          rep_end;
    logic [BW+10:0] sidx_old_ext;
    logic [BW+10:0] sidx_new_ext;
    sjsd_pkg::t_result res_break;
    sjsd_pkg::t_result res_end;
    sjsd_pkg::t_push   push;
    sjsd_pkg::t_push   push_q;

    logic        fire;
    logic        accept;
    logic        pop;
    logic [1:0]  q_count;
    logic [2:0]  q_space;
    sjsd_pkg::t_result head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_threshold  <= sjsd_pkg::JUMP_THRESHOLD_RST;
            r_max_length      <= sjsd_pkg::MAX_LENGTH_RST;
            r_max_start_range <= sjsd_pkg::MAX_START_RANGE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sjsd_pkg::CFG_JUMP_THRESHOLD:  r_jump_threshold  <= i_cfg_data;
                sjsd_pkg::CFG_MAX_LENGTH:      r_max_length      <= i_cfg_data[4:0];
                sjsd_pkg::CFG_MAX_START_RANGE: r_max_start_range <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // segment tracking for the item in the input register
    always_comb begin
        n_in_seg  = r_in_seg;
        n_prev    = r_prev;
        n_beam    = r_beam;
        n_sidx    = r_sidx;
        n_srange  = r_srange;
        n_slen    = r_slen;
        taken     = 1'b0;
        rep_break = 1'b0;
        rep_end   = 1'b0;
        diff      = (r_prev > r_in_range) ? (r_prev - r_in_range) : (r_in_range - r_prev);
        cmp       = diff;

        if (r_beam == '0) begin
            n_in_seg = 1'b0;
            n_prev   = 16'd0;
        end else begin
            if (r_in_seg) begin
                if (diff < r_jump_threshold) begin
                    if (r_slen < sjsd_pkg::SEG_LEN_MAX) begin
                        n_slen = r_slen + 5'd1;
                    end
                    n_prev = r_in_range;
                    taken  = 1'b1;
                end else begin
                    // break: close, then judge this sample against zero
                    rep_break = (r_slen <= r_max_length) && (r_srange <= r_max_start_range);
                    n_in_seg  = 1'b0;
                    cmp       = r_in_range;
                end
            end
            if (!taken) begin
                if (cmp >= r_jump_threshold) begin
                    n_in_seg = 1'b1;
                    n_sidx   = r_beam;
                    n_srange = r_in_range;
                    n_slen   = 5'd1;
                end
                n_prev = r_in_range;
            end
        end

        if (r_in_last) begin
            if (n_in_seg) begin
                rep_end = (n_slen <= r_max_length) && (n_srange <= r_max_start_range);
            end
            n_in_seg = 1'b0;
            n_prev   = 16'd0;
            n_beam   = '0;
        end else if (r_beam < BEAM_LAST) begin
            n_beam = r_beam + {{(BW-1){1'b0}}, 1'b1};
        end
    end

    assign sidx_old_ext = {11'd0, r_sidx};
    assign sidx_new_ext = {11'd0, n_sidx};

    always_comb begin
        res_break.start_index   = sidx_old_ext[10:0];
        res_break.start_range   = r_srange;
        res_break.run_length    = r_slen;
        res_break.final_of_item = !rep_end;
        res_end.start_index     = sidx_new_ext[10:0];
        res_end.start_range     = n_srange;
        res_end.run_length      = n_slen;
        res_end.final_of_item   = 1'b1;

        push.count  = 2'd0;
        push.first  = res_end;
        push.second = res_end;
        if (rep_break && rep_end) begin
            push.count = 2'd2;
            push.first = res_break;
        end else if (rep_break) begin
            push.count = 2'd1;
            push.first = res_break;
        end else if (rep_end) begin
            push.count = 2'd1;
        end
    end

    assign pop     = o_valid && !i_stall;
    assign q_space = 3'd2 - {1'b0, q_count} + {2'b0, pop};
    assign fire    = r_in_valid && ({1'b0, push.count} <= q_space);
    assign o_stall = r_in_valid && !fire;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        push_q = push;
        if (!fire) begin
            push_q.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_range <= i_range_mm;
            r_in_last  <= i_scan_end;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_seg   <= 1'b0;
            r_prev     <= 16'd0;
            r_beam     <= '0;
            r_sidx     <= '0;
            r_srange   <= 16'd0;
            r_slen     <= 5'd0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
            if (fire) begin
                r_in_seg <= n_in_seg;
                r_prev   <= n_prev;
                r_beam   <= n_beam;
                r_sidx   <= n_sidx;
                r_srange <= n_srange;
                r_slen   <= n_slen;
            end
        end
    end

    sjsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_q),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_start_index   = head.start_index;
    assign o_start_range   = head.start_range;
    assign o_run_length    = head.run_length;
    assign o_final_of_item = head.final_of_item;

    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_beam == '0 && !r_in_seg))
        else $error("beam index not reset at scan end");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && push.count != 2'd0))
        else $error("stall without pending results");

    a_seg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_seg |-> (r_slen != 5'd0))
        else $error("open segment with zero length");

endmodule
